// ===== rtl/core/utt_pkg.sv =====
package utt_pkg;

	// field widths fixed by the interface
	localparam int unsigned CP_W        = 21;
	localparam int unsigned UNIT_CNT_W  = 16;
	localparam int unsigned COUNT_W_DEF = 16;

	// result queue
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

	// surrogate pair offsets
	localparam logic [CP_W-1:0] SURR_HI_OFS = 21'h00D7C0;
	localparam logic [CP_W-1:0] SURR_LO_OFS = 21'h00DC00;

	// output mode codes
	localparam logic MODE_UTF16 = 1'b0;
	localparam logic MODE_UTF32 = 1'b1;

	// one result beat
	typedef struct packed {
		logic [CP_W-1:0]       code_unit;
		logic                  is_error;
		logic                  run_last;
		logic                  string_end;
		logic [UNIT_CNT_W-1:0] unit_count;
	} res_t;

	// sequence state carried between bytes
	typedef struct packed {
		logic [1:0]      remaining;
		logic [CP_W-1:0] partial;
		logic            discarding;
	} seq_t;

endpackage

// ===== rtl/core/utt_decode.sv =====
module utt_decode
	import utt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
	input  logic                   mode,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_string,
	input  seq_t                   seq_cur,
	input  logic [COUNT_WIDTH-1:0] units_cur,
	output seq_t                   seq_nxt,
	output logic [COUNT_WIDTH-1:0] units_nxt,
	output logic [1:0]             n_res,
	output res_t                   res0,
	output res_t                   res1
);

	logic [2:0]             ones;
	logic                   emit;
	logic                   err;
	logic [CP_W-1:0]        cp;
	logic                   pair;
	logic [1:0]             n_units;
	logic [COUNT_WIDTH:0]   units_add;
	logic [COUNT_WIDTH-1:0] units_sat;
	logic [COUNT_WIDTH+UNIT_CNT_W-1:0] units_ext;
	logic [UNIT_CNT_W-1:0]  units_rep;
	res_t                   last_res;

	// count leading ones of the byte, five or more folded together
	always_comb begin
		priority casez (data_byte)
			8'b0???????: ones = 3'd0;
			8'b10??????: ones = 3'd1;
			8'b110?????: ones = 3'd2;
			8'b1110????: ones = 3'd3;
			8'b11110???: ones = 3'd4;
			default:     ones = 3'd5;
		endcase
	end

	// sequence tracking: lead byte, continuation byte, discard
	always_comb begin
		seq_nxt = seq_cur;
		emit    = 1'b0;
		err     = 1'b0;
		cp      = '0;
		if (seq_cur.discarding) begin
			if (end_of_string) begin
				seq_nxt.discarding = 1'b0;
			end
		end else if (seq_cur.remaining == 2'd0) begin
			unique case (ones)
				3'd0: begin
					emit = 1'b1;
					cp   = {{(CP_W-8){1'b0}}, data_byte};
				end
				3'd2: begin
					seq_nxt.partial   = {{(CP_W-5){1'b0}}, data_byte[4:0]};
					seq_nxt.remaining = 2'd1;
					err               = end_of_string;
				end
				3'd3: begin
					seq_nxt.partial   = {{(CP_W-4){1'b0}}, data_byte[3:0]};
					seq_nxt.remaining = 2'd2;
					err               = end_of_string;
				end
				3'd4: begin
					seq_nxt.partial   = {{(CP_W-3){1'b0}}, data_byte[2:0]};
					seq_nxt.remaining = 2'd3;
					err               = end_of_string;
				end
				default: err = 1'b1;
			endcase
		end else if (data_byte[7:6] != 2'b10) begin
			err = 1'b1;
		end else begin
			seq_nxt.partial   = {seq_cur.partial[CP_W-7:0], data_byte[5:0]};
			seq_nxt.remaining = seq_cur.remaining - 2'd1;
			if (seq_nxt.remaining == 2'd0) begin
				emit = 1'b1;
				cp   = seq_nxt.partial;
			end else begin
				err = end_of_string;
			end
		end

		// an error or a finished string clears the sequence
		if (err || (emit && end_of_string)) begin
			seq_nxt.remaining = 2'd0;
			seq_nxt.partial   = '0;
		end
		if (err) begin
			seq_nxt.discarding = !end_of_string;
		end
	end

	// surrogate pair only in UTF-16 mode above the basic plane
	assign pair    = (mode == MODE_UTF16) && (cp[CP_W-1:16] != '0);
	assign n_units = emit ? (pair ? 2'd2 : 2'd1) : 2'd0;

	// saturating unit count including this byte's units
	assign units_add = {1'b0, units_cur} + {{(COUNT_WIDTH-1){1'b0}}, n_units};
	assign units_sat = units_add[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
	                                          : units_add[COUNT_WIDTH-1:0];
	assign units_ext = {{UNIT_CNT_W{1'b0}}, units_sat};
	assign units_rep = (units_ext[COUNT_WIDTH+UNIT_CNT_W-1:UNIT_CNT_W] != '0)
	                 ? {UNIT_CNT_W{1'b1}} : units_ext[UNIT_CNT_W-1:0];

	always_comb begin
		if (err || (seq_cur.discarding && end_of_string)
		    || (emit && end_of_string)) begin
			units_nxt = '0;
		end else if (emit) begin
			units_nxt = units_sat;
		end else begin
			units_nxt = units_cur;
		end
	end

	// build the result beats
	always_comb begin
		last_res            = '0;
		last_res.run_last   = 1'b1;
		last_res.string_end = end_of_string;
		res0                = '0;
		res1                = '0;
		n_res               = 2'd0;
		if (err) begin
			last_res.is_error = 1'b1;
			res0              = last_res;
			n_res             = 2'd1;
		end else if (emit) begin
			if (end_of_string) begin
				last_res.unit_count = units_rep;
			end
			if (pair) begin
				res0.code_unit     = {10'b0, cp[CP_W-1:10]} + SURR_HI_OFS;
				last_res.code_unit = {{(CP_W-10){1'b0}}, cp[9:0]} + SURR_LO_OFS;
				res1               = last_res;
				n_res              = 2'd2;
			end else begin
				last_res.code_unit = cp;
				res0               = last_res;
				n_res              = 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/utf8_to_utf16_utf32_transcoder.sv =====
// UTF-8 to UTF-16/UTF-32 transcoder. One UTF-8 byte per input beat, with
// end_of_string on the last byte of a string; result beats carry UTF-16 units
// (cfg output_mode 0) or UTF-32 code points (mode 1), one error beat per
// malformed string, and the saturated unit count on a good string's final beat.
// A byte is registered and decoded once the result queue has room for two
// beats; its zero, one or two results go into a four-entry queue, so a byte
// can be taken every cycle while that room lasts. Results leave at one per
// cycle while out_ready is high; sustained rate is one byte per cycle bounded
// by the output port; results are valid only once they sit in the queue.
// Write output_mode only while the block is idle.
module utf8_to_utf16_utf32_transcoder
	import utt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_string,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CP_W-1:0]       code_unit,
	output logic                  is_error,
	output logic                  run_last,
	output logic                  string_end,
	output logic [UNIT_CNT_W-1:0] unit_count
);

	logic                   mode_q;
	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic                   end_of_string_s1;
	seq_t                   seq_q;
	seq_t                   seq_nxt;
	logic [COUNT_WIDTH-1:0] units_q;
	logic [COUNT_WIDTH-1:0] units_nxt;
	logic [1:0]             n_res;
	res_t                   res0;
	res_t                   res1;
	logic                   fire_s1;
	logic [1:0]             push_n;
	logic                   pop;
	res_t                   queue_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_PTR_W:0]     fill_q;
	res_t                   head;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF16;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// decode a registered byte when the queue has room for two beats
	assign fire_s1  = valid_s1 && (fill_q <= (RES_PTR_W+1)'(RES_DEPTH - 2));
	assign in_ready = !valid_s1 || fire_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1     <= data_byte;
			end_of_string_s1 <= end_of_string;
		end
	end

	utt_decode #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decode (
		.mode         (mode_q),
		.data_byte    (data_byte_s1),
		.end_of_string(end_of_string_s1),
		.seq_cur      (seq_q),
		.units_cur    (units_q),
		.seq_nxt      (seq_nxt),
		.units_nxt    (units_nxt),
		.n_res        (n_res),
		.res0         (res0),
		.res1         (res1)
	);

	// sequence state and unit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			units_q <= '0;
		end else if (fire_s1) begin
			seq_q   <= seq_nxt;
			units_q <= units_nxt;
		end
	end

	// result queue
	assign push_n = fire_s1 ? n_res : 2'd0;
	assign pop    = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + RES_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			fill_q <= fill_q + (RES_PTR_W+1)'(push_n) - (RES_PTR_W+1)'(pop);
		end
	end

	// head beat to the output
	assign head       = queue_q[rd_ptr_q];
	assign out_valid  = (fill_q != '0);
	assign code_unit  = head.code_unit;
	assign is_error   = head.is_error;
	assign run_last   = head.run_last;
	assign string_end = head.string_end;
	assign unit_count = head.unit_count;

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (RES_PTR_W+1)'(RES_DEPTH))
	else $error("result queue overfilled");

	// error beats carry no unit and no count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> run_last && code_unit == '0 && unit_count == '0)
	else $error("malformed error beat");

	// an error before the end of a string starts discarding
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && n_res == 2'd1 && res0.is_error && !end_of_string_s1
		|=> seq_q.discarding)
	else $error("discard not entered after error");

	// while discarding nothing is queued
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && seq_q.discarding |-> push_n == 2'd0)
	else $error("result queued while discarding");

endmodule
